// File: rtl/core/bpr_pkg.sv
`default_nettype none

package bpr_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned EXT_W   = COORD_W - 1;
  localparam int unsigned WIDE_W  = COORD_W + 2;
  localparam int unsigned SPAN_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * SPAN_W;
  localparam int unsigned VOL_W   = 64;
  localparam int unsigned DIST_W  = 48;
  localparam int unsigned DSUM_W  = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
  localparam int unsigned PROD_W  = VOL_W + SPAN_W;

  localparam int unsigned A_START_LSB = 0;
  localparam int unsigned A_EXT_LSB   = A_START_LSB + COORD_W;
  localparam int unsigned B_START_LSB = A_EXT_LSB + EXT_W;
  localparam int unsigned B_EXT_LSB   = B_START_LSB + COORD_W;
  localparam int unsigned POINT_LSB   = B_EXT_LSB + EXT_W;
  localparam int unsigned IN_BITS     = POINT_LSB + COORD_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  localparam int unsigned CONTAIN_BIT = 0;
  localparam int unsigned OVERLAP_BIT = 1;
  localparam int unsigned VOL_A_LSB   = 2;
  localparam int unsigned ENLARGE_LSB = VOL_A_LSB + VOL_W;
  localparam int unsigned DIST_LSB    = ENLARGE_LSB + VOL_W;
  localparam int unsigned SAT_BIT     = DIST_LSB + DIST_W;
  localparam int unsigned OUT_BITS    = SAT_BIT + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [VOL_W-1:0]  VOL_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic              contain_fail;
    logic              overlap_fail;
    logic [EXT_W-1:0]  ext_a;
    logic [SPAN_W-1:0] span;
    logic [SQ_W-1:0]   sq;
    logic              last;
  } dim_t;

  typedef struct packed {
    logic              contains;
    logic              overlap;
    logic [VOL_W-1:0]  vol_a;
    logic [VOL_W-1:0]  vol_m;
    logic [DIST_W-1:0] dist_sum;
    logic              sat;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/bpr_front.sv
`default_nettype none

module bpr_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bpr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                            s_axis_tlast,
  output logic                                 dim_valid_o,
  input  wire logic                            dim_ready_i,
  output bpr_pkg::dim_t                        dim_o
);

  logic signed [bpr_pkg::COORD_W-1:0] a_start, b_start, point;
  logic [bpr_pkg::EXT_W-1:0]          a_ext, b_ext;
  logic signed [bpr_pkg::WIDE_W-1:0]  as_w, ae_w, bs_w, be_w, p_w;
  logic signed [bpr_pkg::WIDE_W-1:0]  lo_w, hi_w, span_w, d_w;
  logic [bpr_pkg::SPAN_W-1:0]         d;
  bpr_pkg::dim_t                      dim_d, dim_q;
  logic                               valid_d, valid_q;

  assign a_start = s_axis_tdata[bpr_pkg::A_START_LSB +: bpr_pkg::COORD_W];
  assign a_ext   = s_axis_tdata[bpr_pkg::A_EXT_LSB +: bpr_pkg::EXT_W];
  assign b_start = s_axis_tdata[bpr_pkg::B_START_LSB +: bpr_pkg::COORD_W];
  assign b_ext   = s_axis_tdata[bpr_pkg::B_EXT_LSB +: bpr_pkg::EXT_W];
  assign point   = s_axis_tdata[bpr_pkg::POINT_LSB +: bpr_pkg::COORD_W];

  always_comb begin
    as_w = bpr_pkg::WIDE_W'(a_start);
    bs_w = bpr_pkg::WIDE_W'(b_start);
    p_w  = bpr_pkg::WIDE_W'(point);
    ae_w = as_w + bpr_pkg::WIDE_W'(a_ext);
    be_w = bs_w + bpr_pkg::WIDE_W'(b_ext);
    lo_w = (as_w < bs_w) ? as_w : bs_w;
    hi_w = (ae_w > be_w) ? ae_w : be_w;
    span_w = hi_w - lo_w;
    if (p_w < as_w) begin
      d_w = as_w - p_w;
    end else if (p_w > ae_w) begin
      d_w = p_w - ae_w;
    end else begin
      d_w = '0;
    end
    d = d_w[bpr_pkg::SPAN_W-1:0];
    dim_d.contain_fail = (as_w > bs_w) || (ae_w < be_w);
    dim_d.overlap_fail = (ae_w < bs_w) || (be_w < as_w);
    dim_d.ext_a        = a_ext;
    dim_d.span         = span_w[bpr_pkg::SPAN_W-1:0];
    dim_d.sq           = {{bpr_pkg::SPAN_W{1'b0}}, d} * {{bpr_pkg::SPAN_W{1'b0}}, d};
    dim_d.last         = s_axis_tlast;
  end

  assign s_axis_tready = !valid_q || dim_ready_i;
  assign valid_d       = s_axis_tready ? s_axis_tvalid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      dim_q <= dim_d;
    end
  end

  assign dim_valid_o = valid_q;
  assign dim_o       = dim_q;

endmodule

`default_nettype wire

// File: rtl/core/bpr_fifo.sv
`default_nettype none

module bpr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire bpr_pkg::dim_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output bpr_pkg::dim_t      pop_data_o
);

  bpr_pkg::dim_t                   mem_q [bpr_pkg::FIFO_DEPTH];
  logic [bpr_pkg::FIFO_PTR_W-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [bpr_pkg::FIFO_CNT_W-1:0]  cnt_d, cnt_q;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != bpr_pkg::FIFO_CNT_W'(bpr_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bpr_back.sv
`default_nettype none

module bpr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          dim_valid_i,
  output logic               dim_ready_o,
  input  wire bpr_pkg::dim_t dim_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output bpr_pkg::res_t      res_o
);

  logic                           contain_d, contain_q, overlap_d, overlap_q;
  logic                           sat_d, sat_q;
  logic [bpr_pkg::VOL_W-1:0]      vol_a_d, vol_a_q, vol_m_d, vol_m_q;
  logic [bpr_pkg::DIST_W-1:0]     dist_d, dist_q;
  logic [bpr_pkg::PROD_W-1:0]     prod_a, prod_m;
  logic [bpr_pkg::DSUM_W-1:0]     dsum;
  logic                           sat_a, sat_m, sat_dist;
  logic [bpr_pkg::VOL_W-1:0]      vol_a_new, vol_m_new;
  logic [bpr_pkg::DIST_W-1:0]     dist_new;
  logic                           out_free, take;
  logic                           res_valid_d, res_valid_q;
  bpr_pkg::res_t                  res_d, res_q;

  assign out_free    = !res_valid_q || res_ready_i;
  assign dim_ready_o = !dim_i.last || out_free;
  assign take        = dim_valid_i && dim_ready_o;

  always_comb begin
    prod_a = {{bpr_pkg::SPAN_W{1'b0}}, vol_a_q}
           * {{(bpr_pkg::PROD_W - bpr_pkg::EXT_W){1'b0}}, dim_i.ext_a};
    prod_m = {{bpr_pkg::SPAN_W{1'b0}}, vol_m_q}
           * {{bpr_pkg::VOL_W{1'b0}}, dim_i.span};
    sat_a  = |prod_a[bpr_pkg::PROD_W-1:bpr_pkg::VOL_W];
    sat_m  = |prod_m[bpr_pkg::PROD_W-1:bpr_pkg::VOL_W];
    vol_a_new = sat_a ? bpr_pkg::VOL_MAX : prod_a[bpr_pkg::VOL_W-1:0];
    vol_m_new = sat_m ? bpr_pkg::VOL_MAX : prod_m[bpr_pkg::VOL_W-1:0];
    dsum = bpr_pkg::DSUM_W'(dist_q) + bpr_pkg::DSUM_W'(dim_i.sq);
    sat_dist = dsum > bpr_pkg::DSUM_W'(bpr_pkg::DIST_MAX);
    dist_new = sat_dist ? bpr_pkg::DIST_MAX : dsum[bpr_pkg::DIST_W-1:0];

    res_d.contains = contain_q && !dim_i.contain_fail;
    res_d.overlap  = overlap_q && !dim_i.overlap_fail;
    res_d.vol_a    = vol_a_new;
    res_d.vol_m    = vol_m_new;
    res_d.dist_sum = dist_new;
    res_d.sat      = sat_q || sat_a || sat_m || sat_dist;

    contain_d = contain_q;
    overlap_d = overlap_q;
    vol_a_d   = vol_a_q;
    vol_m_d   = vol_m_q;
    dist_d    = dist_q;
    sat_d     = sat_q;
    if (take) begin
      if (dim_i.last) begin
        contain_d = 1'b1;
        overlap_d = 1'b1;
        vol_a_d   = bpr_pkg::VOL_W'(1);
        vol_m_d   = bpr_pkg::VOL_W'(1);
        dist_d    = '0;
        sat_d     = 1'b0;
      end else begin
        contain_d = res_d.contains;
        overlap_d = res_d.overlap;
        vol_a_d   = vol_a_new;
        vol_m_d   = vol_m_new;
        dist_d    = dist_new;
        sat_d     = res_d.sat;
      end
    end

    if (take && dim_i.last) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contain_q   <= 1'b1;
      overlap_q   <= 1'b1;
      vol_a_q     <= bpr_pkg::VOL_W'(1);
      vol_m_q     <= bpr_pkg::VOL_W'(1);
      dist_q      <= '0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      contain_q   <= contain_d;
      overlap_q   <= overlap_d;
      vol_a_q     <= vol_a_d;
      vol_m_q     <= vol_m_d;
      dist_q      <= dist_d;
      sat_q       <= sat_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && dim_i.last) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: rtl/core/box_pair_relation_unit.sv
// Box pair relation unit: containment, overlap, volume, enlargement and
// point distance for two axis-aligned boxes, one dimension per transaction.
// Slave channel: each transaction carries one dimension of A, B and the query
// point; tlast marks the final dimension of a pair. Master channel: one result
// transaction per pair, issued for the transaction that carried tlast.
// Throughput: one dimension per clock cycle unless a final dimension waits
// on a stalled result; after the front register and the queue, the result
// is registered. The accumulate stage sets the rate, folding per dimension
// a saturating product of up to 64 x 17 bits per volume and one distance add.
// A front stage classifies each dimension and squares the clamped distance;
// a four-entry queue separates it from the accumulate stage.
// Reset clears all accumulators to an empty pair and drops any pending result.
// When the receiver stalls, the result is held in the output register; the
// front keeps taking dimensions until the queue fills, and only a final
// dimension waits for the output register to free up.
`default_nettype none

module box_pair_relation_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // a_start, a_extent, b_start, b_extent, point_coord, zero pad
  input  wire logic [bpr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // a_contains_b, boxes_overlap, volume_a, enlargement, min_dist_sq,
  // saturated, zero pad
  output logic [bpr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  logic          f_valid, f_ready, b_valid, b_ready;
  bpr_pkg::dim_t f_dim, b_dim;
  bpr_pkg::res_t res;

  bpr_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .dim_valid_o (f_valid),
    .dim_ready_i (f_ready),
    .dim_o       (f_dim)
  );

  bpr_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_dim),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_dim)
  );

  bpr_back u_back (
    .clk_i,
    .rst_ni,
    .dim_valid_i (b_valid),
    .dim_ready_o (b_ready),
    .dim_i       (b_dim),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[bpr_pkg::CONTAIN_BIT] = res.contains;
    m_axis_tdata[bpr_pkg::OVERLAP_BIT] = res.overlap;
    m_axis_tdata[bpr_pkg::VOL_A_LSB +: bpr_pkg::VOL_W] = res.vol_a;
    m_axis_tdata[bpr_pkg::ENLARGE_LSB +: bpr_pkg::VOL_W] =
      (res.vol_m >= res.vol_a) ? (res.vol_m - res.vol_a) : '0;
    m_axis_tdata[bpr_pkg::DIST_LSB +: bpr_pkg::DIST_W] = res.dist_sum;
    m_axis_tdata[bpr_pkg::SAT_BIT] = res.sat;
  end

endmodule

`default_nettype wire

// File: rtl/core/bpr_port_checker.sv
`default_nettype none

module bpr_port_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            s_axis_tlast,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [bpr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [2:0] pend_d, pend_q;
  logic       s_last_fire, m_fire;

  assign s_last_fire = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign m_fire      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    unique case ({s_last_fire, m_fire})
      2'b10:   pend_d = pend_q + 1'b1;
      2'b01:   pend_d = pend_q - 1'b1;
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("result without a final dimension");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd6)
    else $error("more pairs in flight than storage allows");

  a_contain_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[bpr_pkg::CONTAIN_BIT]
      |-> m_axis_tdata[bpr_pkg::OVERLAP_BIT])
    else $error("containment without overlap");

endmodule

bind box_pair_relation_unit bpr_port_checker u_port_checker (.*);

`default_nettype wire

// File: tb/sv/box_pair_checker.sv
`timescale 1ns / 100ps

module box_pair_checker
  import bpr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  // a_start, a_extent, b_start, b_extent, point_coord, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  input  wire logic                   in_last_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  // a_contains_b, boxes_overlap, volume_a, enlargement, min_dist_sq,
  // saturated, zero pad
  input  wire logic [OUT_TDATA_W-1:0] out_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 results_owed_o
);

  typedef struct packed {
    logic              contains;
    logic              overlap;
    logic [VOL_W-1:0]  vol_a;
    logic [VOL_W-1:0]  enlarge;
    logic [DIST_W-1:0] dist_sum;
    logic              sat;
  } pair_result_t;

  logic              contain_ok;
  logic              overlap_ok;
  logic              sat_seen;
  logic [VOL_W-1:0]  vol_a_run;
  logic [VOL_W-1:0]  vol_bound_run;
  logic [DIST_W-1:0] dist_run;
  pair_result_t      owed_q[$];
  int unsigned       mismatches;
  int unsigned       owed_count;

  assign fail_count_o   = mismatches;
  assign results_owed_o = owed_count;

  task automatic clear_pair();
    contain_ok    = 1'b1;
    overlap_ok    = 1'b1;
    sat_seen      = 1'b0;
    vol_a_run     = VOL_W'(1);
    vol_bound_run = VOL_W'(1);
    dist_run      = '0;
  endtask

  function automatic logic [VOL_W-1:0] saturating_mul(input logic [VOL_W-1:0] acc,
                                                      input int unsigned factor);
    logic [PROD_W-1:0] wide_acc;
    logic [PROD_W-1:0] wide_factor;
    logic [PROD_W-1:0] prod;
    wide_acc    = PROD_W'(acc);
    wide_factor = PROD_W'(factor);
    prod        = wide_acc * wide_factor;
    if (prod[PROD_W-1:VOL_W] != '0) begin
      sat_seen = 1'b1;
      return VOL_MAX;
    end
    return prod[VOL_W-1:0];
  endfunction

  task automatic fold_dimension(input logic [IN_TDATA_W-1:0] word, input logic last);
    int           a_lo;
    int           a_len;
    int           b_lo;
    int           b_len;
    int           pt;
    int           a_hi;
    int           b_hi;
    int           lo;
    int           hi;
    int           near;
    int           gap;
    logic [63:0]  gap64;
    logic [63:0]  sq;
    logic [DIST_W:0] dsum;
    pair_result_t res;
    a_lo  = int'($signed(word[A_START_LSB +: COORD_W]));
    a_len = int'(word[A_EXT_LSB +: EXT_W]);
    b_lo  = int'($signed(word[B_START_LSB +: COORD_W]));
    b_len = int'(word[B_EXT_LSB +: EXT_W]);
    pt    = int'($signed(word[POINT_LSB +: COORD_W]));
    a_hi  = a_lo + a_len;
    b_hi  = b_lo + b_len;

    if (a_lo > b_lo || a_hi < b_hi) contain_ok = 1'b0;
    if (a_hi < b_lo || b_hi < a_lo) overlap_ok = 1'b0;

    lo = (a_lo < b_lo) ? a_lo : b_lo;
    hi = (a_hi > b_hi) ? a_hi : b_hi;
    vol_a_run     = saturating_mul(vol_a_run, a_len);
    vol_bound_run = saturating_mul(vol_bound_run, hi - lo);

    // clamp the point onto A
    if (pt < a_lo) near = a_lo;
    else if (pt > a_hi) near = a_hi;
    else near = pt;
    gap = pt - near;
    if (gap < 0) gap = -gap;
    gap64 = 64'(gap);
    sq    = gap64 * gap64;
    dsum  = (DIST_W + 1)'(dist_run) + (DIST_W + 1)'(sq);
    if (dsum > {1'b0, DIST_MAX}) begin
      dist_run = DIST_MAX;
      sat_seen = 1'b1;
    end else begin
      dist_run = dsum[DIST_W-1:0];
    end

    if (last) begin
      res.contains = contain_ok;
      res.overlap  = overlap_ok;
      res.vol_a    = vol_a_run;
      res.enlarge  = (vol_bound_run >= vol_a_run) ? vol_bound_run - vol_a_run : '0;
      res.dist_sum = dist_run;
      res.sat      = sat_seen;
      owed_q.push_back(res);
      clear_pair();
    end
  endtask

  task automatic compare_field(input string name, input logic [VOL_W-1:0] want,
                               input logic [VOL_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
    pair_result_t want;
    if (owed_q.size() == 0) begin
      $error("result transaction with no pair pending: 0x%0h", word);
      mismatches++;
      return;
    end
    want = owed_q.pop_front();
    compare_field("a_contains_b", VOL_W'(want.contains), VOL_W'(word[CONTAIN_BIT]));
    compare_field("boxes_overlap", VOL_W'(want.overlap), VOL_W'(word[OVERLAP_BIT]));
    compare_field("volume_a", want.vol_a, word[VOL_A_LSB +: VOL_W]);
    compare_field("enlargement", want.enlarge, word[ENLARGE_LSB +: VOL_W]);
    compare_field("min_dist_sq", VOL_W'(want.dist_sum), VOL_W'(word[DIST_LSB +: DIST_W]));
    compare_field("saturated", VOL_W'(want.sat), VOL_W'(word[SAT_BIT]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_pair();
      owed_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) fold_dimension(in_data_i, in_last_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
    end
    owed_count = owed_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bpr_pkg::*;

  localparam int unsigned RANDOM_DIMS    = 950;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int          COORD_MIN      = -32768;
  localparam int          COORD_MAX      = 32767;

  typedef struct {
    logic [COORD_W-1:0] a_start;
    logic [EXT_W-1:0]   a_ext;
    logic [COORD_W-1:0] b_start;
    logic [EXT_W-1:0]   b_ext;
    logic [COORD_W-1:0] point;
    logic               last;
  } dim_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  bit                     tx_idle_en = 1'b1;
  bit                     rx_idle_en = 1'b1;
  int unsigned            fail_count;
  int unsigned            results_owed;
  int unsigned            cycle_count = 0;

  always #10 clk_i = ~clk_i;

  box_pair_relation_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  box_pair_checker u_pair_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_i     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .in_last_i      (s_axis_tlast),
    .out_valid_i    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_i     (m_axis_tdata),
    .fail_count_o   (fail_count),
    .results_owed_o (results_owed)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  always begin
    int unsigned stall;
    @(negedge clk_i);
    stall = rx_idle_en ? $urandom_range(0, 15) : 0;
    if (stall != 0) begin
      m_axis_tready <= 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
    do @(posedge clk_i); while (!m_axis_tvalid);
  end

  function automatic dim_item_t make_dim(input int a_lo, input int a_len, input int b_lo,
                                         input int b_len, input int pt, input bit last);
    dim_item_t d;
    d.a_start = a_lo[COORD_W-1:0];
    d.a_ext   = a_len[EXT_W-1:0];
    d.b_start = b_lo[COORD_W-1:0];
    d.b_ext   = b_len[EXT_W-1:0];
    d.point   = pt[COORD_W-1:0];
    d.last    = last;
    return d;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) + COORD_MIN;
  endfunction

  function automatic int pick_extreme_coord();
    case ($urandom_range(0, 3))
      0: return COORD_MIN;
      1: return -1;
      2: return 0;
      default: return COORD_MAX;
    endcase
  endfunction

  function automatic int pick_extreme_extent();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 1;
      default: return COORD_MAX;
    endcase
  endfunction

  function automatic dim_item_t random_dim(input bit last);
    int shape;
    int a_lo;
    int a_len;
    int b_lo;
    int b_len;
    int pt;
    int tmp;
    shape = $urandom_range(0, 5);
    a_lo  = rand_coord();
    b_lo  = rand_coord();
    a_len = $urandom_range(0, COORD_MAX);
    b_len = $urandom_range(0, COORD_MAX);
    pt    = rand_coord();
    case (shape)
      1: begin
        a_lo  = -int'($urandom_range(0, 32768));
        b_lo  = a_lo + int'($urandom_range(0, a_len));
        b_len = $urandom_range(0, a_lo + a_len - b_lo);
      end
      2: begin
        a_lo = -int'($urandom_range(0, 32768));
        b_lo = a_lo + a_len;
      end
      3: begin
        a_lo = $urandom_range(0, COORD_MAX);
        b_lo = a_lo - b_len;
      end
      4: begin
        a_lo = -int'($urandom_range(1, 32768));
        b_lo = a_lo + a_len + 1;
      end
      5: begin
        a_lo  = pick_extreme_coord();
        b_lo  = pick_extreme_coord();
        a_len = pick_extreme_extent();
        b_len = pick_extreme_extent();
        pt    = pick_extreme_coord();
      end
      default: ;
    endcase
    if (shape >= 1 && shape <= 4 && $urandom_range(0, 1) == 1) begin
      tmp = a_lo;  a_lo  = b_lo;  b_lo  = tmp;
      tmp = a_len; a_len = b_len; b_len = tmp;
    end
    if (shape != 5) begin
      case ($urandom_range(0, 3))
        1: begin
          pt = a_lo + int'($urandom_range(0, a_len));
          if (pt > COORD_MAX) pt = COORD_MAX;
        end
        2: if (a_lo > COORD_MIN) pt = a_lo - 1;
        3: if (a_lo + a_len < COORD_MAX) pt = a_lo + a_len + 1;
        default: ;
      endcase
    end
    return make_dim(a_lo, a_len, b_lo, b_len, pt, last);
  endfunction

  task automatic drive_dim(input dim_item_t d);
    int unsigned           gap;
    logic [IN_TDATA_W-1:0] word;
    gap  = tx_idle_en ? $urandom_range(0, 15) : 0;
    word = '0;
    word[A_START_LSB +: COORD_W] = d.a_start;
    word[A_EXT_LSB +: EXT_W]     = d.a_ext;
    word[B_START_LSB +: COORD_W] = d.b_start;
    word[B_EXT_LSB +: EXT_W]     = d.b_ext;
    word[POINT_LSB +: COORD_W]   = d.point;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= word;
    s_axis_tlast  <= d.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic await_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
  endtask

  task automatic send_random_pair(output int unsigned dims);
    dims = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    for (int unsigned i = 0; i < dims; i++) begin
      drive_dim(random_dim(i == dims - 1));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned dims;
    sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero extents at the origin
    drive_dim(make_dim(0, 0, 0, 0, 0, 1'b1));
    // opposite extremes, disjoint, point above A
    drive_dim(make_dim(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    // largest clamped distance, point below A
    drive_dim(make_dim(COORD_MAX, COORD_MAX, COORD_MIN, 0, COORD_MIN, 1'b1));
    // equal boxes
    drive_dim(make_dim(-5, 10, -5, 10, 0, 1'b1));
    // B touching the top of A, then B ending where A starts
    drive_dim(make_dim(100, 50, 150, 20, 149, 1'b0));
    drive_dim(make_dim(100, 50, 80, 20, 151, 1'b1));
    // both volumes saturate, then a zero extent of A clears its volume
    repeat (5) drive_dim(make_dim(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0, 1'b0));
    drive_dim(make_dim(0, 0, -10, 20, 5, 1'b1));
    // bounding volume saturates while A stays unit sized
    repeat (4) drive_dim(make_dim(COORD_MIN, 1, COORD_MAX, 0, -32767, 1'b0));
    drive_dim(make_dim(COORD_MIN, 1, COORD_MAX, 0, -32767, 1'b1));
    await_results();

    while (sent < RANDOM_DIMS) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_idle_en = ($urandom_range(0, 2) != 0);
        rx_idle_en = ($urandom_range(0, 2) != 0);
      end
      send_random_pair(dims);
      sent += dims;
      if ($urandom_range(0, 19) == 0) await_results();
    end

    await_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bpr_pkg.sv
rtl/core/bpr_front.sv
rtl/core/bpr_fifo.sv
rtl/core/bpr_back.sv
rtl/core/box_pair_relation_unit.sv
rtl/core/bpr_port_checker.sv
tb/sv/box_pair_checker.sv
tb/sv/testbench.sv
